// ===== src/trimmed_mean_window_filter_unit_defines.svh =====
// Assertion macros used by the checker file of the filter.
`ifndef TRIMMED_MEAN_WINDOW_FILTER_UNIT_DEFINES_SVH
`define TRIMMED_MEAN_WINDOW_FILTER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TMWF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("filter assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define TMWF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("filter assertion failed");

`endif

// ===== src/tmwf_pkg.sv =====
package tmwf_pkg;

  typedef logic [2:0] upc_t;

  // Microprogram addresses.
  localparam upc_t UPC_IDLE  = 3'd0;
  localparam upc_t UPC_CHECK = 3'd1;
  localparam upc_t UPC_SCAN  = 3'd2;
  localparam upc_t UPC_TRIM  = 3'd3;
  localparam upc_t UPC_DIV   = 3'd4;
  localparam upc_t UPC_EMIT  = 3'd5;

  typedef enum logic [2:0] {
    OP_LOAD,
    OP_SCAN_INIT,
    OP_SCAN,
    OP_TRIM,
    OP_DIV,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_IN_VALID,
    COND_FULL,
    COND_SCAN_LAST,
    COND_DIV_LAST,
    COND_OUT_FREE
  } cond_e;

  // One control word: the operation, and the jump taken when the condition holds.
  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  tgt;
    upc_t  nxt;
  } ucode_t;

  // Decoded strobes from the sequencer to the datapath.
  typedef struct packed {
    logic idle;
    logic load;
    logic scan_init;
    logic scan_step;
    logic trim;
    logic div_step;
    logic emit;
  } ctrl_t;

  // Status flags from the datapath back to the sequencer.
  typedef struct packed {
    logic full;
    logic scan_last;
    logic div_last;
    logic out_free;
  } stat_t;

  function automatic ucode_t ucode_rom(input upc_t addr);
    ucode_t word;
    case (addr)
      UPC_IDLE:  word = '{op: OP_LOAD,      cond: COND_IN_VALID,  tgt: UPC_CHECK, nxt: UPC_IDLE};
      UPC_CHECK: word = '{op: OP_SCAN_INIT, cond: COND_FULL,      tgt: UPC_SCAN,  nxt: UPC_EMIT};
      UPC_SCAN:  word = '{op: OP_SCAN,      cond: COND_SCAN_LAST, tgt: UPC_TRIM,  nxt: UPC_SCAN};
      UPC_TRIM:  word = '{op: OP_TRIM,      cond: COND_ALWAYS,    tgt: UPC_DIV,   nxt: UPC_DIV};
      UPC_DIV:   word = '{op: OP_DIV,       cond: COND_DIV_LAST,  tgt: UPC_EMIT,  nxt: UPC_DIV};
      UPC_EMIT:  word = '{op: OP_EMIT,      cond: COND_OUT_FREE,  tgt: UPC_IDLE,  nxt: UPC_EMIT};
      default:   word = '{op: OP_LOAD,      cond: COND_ALWAYS,    tgt: UPC_IDLE,  nxt: UPC_IDLE};
    endcase
    return word;
  endfunction

endpackage

// ===== src/trimmed_mean_window_filter_unit.sv =====
// Trimmed-mean moving-average filter for signed fixed-point angle samples.
// Input channel: in_valid_i / in_stall_o carry one sample request on sample_in_i.
// Output channel: out_valid_o / out_stall_i carry one result request on filtered_out_o.
// A request moves on a rising edge with valid high and stall low.
// Every sample gives exactly one result. Until the window has been filled the sample
// passes straight through; from then on the result is the window sum minus one
// largest and one smallest entry, divided by WINDOW_DEPTH - 2, truncated toward zero.
// A microcoded sequencer steps a small datapath: one window entry is read per cycle
// for the max/min/sum scan, and the division is a multiply by a scaled reciprocal
// in one step followed by a step that restores the sign.
// Passthrough runs the idle, check and emit steps; filtering runs idle, check,
// the scan over the window, trim, the divider steps and emit. A new sample is
// taken only once the sequence is back at the idle step.
// The result sits in an output register; while the receiver stalls it is held, the
// next sample is still taken and worked on, and that result waits in the last step.
// Reset empties the window and clears the output valid; samples are accepted in the
// first cycle after reset.
module trimmed_mean_window_filter_unit #(
  parameter int WINDOW_DEPTH = 8,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [SAMPLE_WIDTH-1:0] filtered_out_o
);
  import tmwf_pkg::*;

  localparam int SumW = SAMPLE_WIDTH + $clog2(WINDOW_DEPTH);

  ctrl_t                          ctrl;
  stat_t                          stat;
  logic                           full, scan_last, div_last, neg;
  logic        [SumW-1:0]         mag;
  logic        [SAMPLE_WIDTH-1:0] quot;
  logic signed [SAMPLE_WIDTH-1:0] result_q, filtered_q;
  logic                           out_valid_q;

  // The output register can take a new result when empty or being drained now.
  assign stat.full      = full;
  assign stat.scan_last = scan_last;
  assign stat.div_last  = div_last;
  assign stat.out_free  = !out_valid_q || !out_stall_i;

  // Samples are taken only at the idle step of the microprogram.
  assign in_stall_o     = !ctrl.idle;
  assign out_valid_o    = out_valid_q;
  assign filtered_out_o = filtered_q;

  tmwf_sequencer u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  tmwf_datapath #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .sample_i    (sample_in_i),
    .full_o      (full),
    .scan_last_o (scan_last),
    .mag_o       (mag),
    .neg_o       (neg)
  );

  tmwf_divider #(
    .WINDOW_DEPTH (WINDOW_DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctrl.trim),
    .step_i  (ctrl.div_step),
    .mag_i   (mag),
    .neg_i   (neg),
    .last_o  (div_last),
    .quot_o  (quot)
  );

  // The result register holds the passthrough sample, and is overwritten by the
  // signed quotient on the last divider step when the window is full.
  always_ff @(posedge clk_i) begin
    if (ctrl.load) begin
      result_q <= sample_in_i;
    end else if (ctrl.div_step && div_last) begin
      result_q <= $signed(quot);
    end
    if (ctrl.emit) begin
      filtered_q <= result_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

endmodule

// ===== src/tmwf_sequencer.sv =====
module tmwf_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  tmwf_pkg::stat_t stat_i,
  output tmwf_pkg::ctrl_t ctrl_o
);
  import tmwf_pkg::*;

  upc_t   pc_q, pc_d;
  ucode_t word;
  logic   cond_met;

  always_comb begin
    word = ucode_rom(pc_q);
    unique case (word.cond)
      COND_ALWAYS:    cond_met = 1'b1;
      COND_IN_VALID:  cond_met = in_valid_i;
      COND_FULL:      cond_met = stat_i.full;
      COND_SCAN_LAST: cond_met = stat_i.scan_last;
      COND_DIV_LAST:  cond_met = stat_i.div_last;
      COND_OUT_FREE:  cond_met = stat_i.out_free;
      default:        cond_met = 1'b1;
    endcase
    pc_d = cond_met ? word.tgt : word.nxt;
  end

  always_comb begin
    ctrl_o = '0;
    unique case (word.op)
      OP_LOAD: begin
        ctrl_o.idle = 1'b1;
        ctrl_o.load = in_valid_i;
      end
      OP_SCAN_INIT: ctrl_o.scan_init = 1'b1;
      OP_SCAN:      ctrl_o.scan_step = 1'b1;
      OP_TRIM:      ctrl_o.trim      = 1'b1;
      OP_DIV:       ctrl_o.div_step  = 1'b1;
      OP_EMIT:      ctrl_o.emit      = stat_i.out_free;
      default:      ctrl_o           = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= UPC_IDLE;
    end else begin
      pc_q <= pc_d;
    end
  end

endmodule

// ===== src/tmwf_datapath.sv =====
module tmwf_datapath #(
  parameter  int WINDOW_DEPTH = 8,
  parameter  int SAMPLE_WIDTH = 16,
  localparam int SumW         = SAMPLE_WIDTH + $clog2(WINDOW_DEPTH)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  tmwf_pkg::ctrl_t                ctrl_i,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_i,
  output logic                           full_o,
  output logic                           scan_last_o,
  output logic        [SumW-1:0]         mag_o,
  output logic                           neg_o
);
  import tmwf_pkg::*;

  localparam int PtrW = $clog2(WINDOW_DEPTH);

  logic signed [SAMPLE_WIDTH-1:0] store_q [WINDOW_DEPTH];
  logic        [PtrW-1:0]         wr_ptr_q, idx_q;
  logic                           full_q;
  logic signed [SAMPLE_WIDTH-1:0] hi_q, lo_q, elem;
  logic signed [SumW-1:0]         sum_q, trimmed;

  assign elem        = store_q[idx_q];
  assign full_o      = full_q;
  assign scan_last_o = (idx_q == PtrW'(WINDOW_DEPTH - 1));

  // Drop one largest and one smallest entry, then split into sign and magnitude.
  assign trimmed = sum_q - SumW'(hi_q) - SumW'(lo_q);
  assign neg_o   = trimmed[SumW-1];
  assign mag_o   = neg_o ? (SumW'(0) - trimmed) : trimmed;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      store_q[wr_ptr_q] <= sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      full_q   <= 1'b0;
      idx_q    <= '0;
    end else begin
      if (ctrl_i.load) begin
        if (wr_ptr_q == PtrW'(WINDOW_DEPTH - 1)) begin
          wr_ptr_q <= '0;
          full_q   <= 1'b1;
        end else begin
          wr_ptr_q <= wr_ptr_q + 1'b1;
        end
      end
      if (ctrl_i.scan_init) begin
        idx_q <= PtrW'(1);
      end else if (ctrl_i.scan_step) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.scan_init) begin
      hi_q  <= store_q[0];
      lo_q  <= store_q[0];
      sum_q <= SumW'(store_q[0]);
    end else if (ctrl_i.scan_step) begin
      if (elem > hi_q) begin
        hi_q <= elem;
      end
      if (elem < lo_q) begin
        lo_q <= elem;
      end
      sum_q <= sum_q + SumW'(elem);
    end
  end

endmodule

// ===== src/tmwf_divider.sv =====
module tmwf_divider #(
  parameter  int WINDOW_DEPTH = 8,
  parameter  int SAMPLE_WIDTH = 16,
  localparam int SumW         = SAMPLE_WIDTH + $clog2(WINDOW_DEPTH)
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    step_i,
  input  logic [SumW-1:0]         mag_i,
  input  logic                    neg_i,
  output logic                    last_o,
  output logic [SAMPLE_WIDTH-1:0] quot_o
);

  localparam int Divisor = WINDOW_DEPTH - 2;
  localparam int Shift   = SumW + $clog2(Divisor);
  localparam int RecW    = SumW + 2;
  localparam int PrdW    = SumW + RecW;
  localparam logic [RecW-1:0] Recip =
    RecW'(((64'd1 << Shift) + 64'(Divisor - 1)) / 64'(Divisor));

  logic [SumW-1:0]         mag_q;
  logic [PrdW-1:0]         prod;
  logic [SAMPLE_WIDTH-1:0] quo_q;
  logic                    neg_q;
  logic                    cnt_q;

  // Multiply by the rounded-up reciprocal. The rounding error times the largest
  // magnitude stays below one unit of the shifted product, so the floor is exact.
  assign prod = PrdW'(mag_q) * PrdW'(Recip);

  // The first step takes the quotient magnitude, the second restores the sign.
  assign last_o = cnt_q;
  assign quot_o = neg_q ? (SAMPLE_WIDTH'(0) - quo_q) : quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 1'b0;
    end else if (start_i) begin
      cnt_q <= 1'b0;
    end else if (step_i) begin
      cnt_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      mag_q <= mag_i;
      neg_q <= neg_i;
    end
    if (step_i && !cnt_q) begin
      quo_q <= prod[Shift +: SAMPLE_WIDTH];
    end
  end

endmodule

// ===== src/tmwf_checker.sv =====
`include "trimmed_mean_window_filter_unit_defines.svh"

module tmwf_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           in_valid_i,
  input logic                           in_stall_o,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic signed [SAMPLE_WIDTH-1:0] filtered_out_o
);

  // A stalled result stays offered and unchanged.
  `TMWF_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o)
  `TMWF_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(filtered_out_o))

  // One sample at a time: the block is busy right after taking a request.
  `TMWF_ASSERT_NEXT(a_busy_after_take, clk_i, rst_ni, in_valid_i && !in_stall_o, in_stall_o)

  // No result can appear in the cycle right after a sample is taken.
  `TMWF_ASSERT_NEXT(a_no_early_result, clk_i, rst_ni, in_valid_i && !in_stall_o, !$rose(out_valid_o))

  // Handing over a result returns the sequencer to the idle step.
  `TMWF_ASSERT_NOW(a_idle_after_emit, clk_i, rst_ni, $rose(out_valid_o), !in_stall_o)

endmodule

bind trimmed_mean_window_filter_unit tmwf_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_tmwf_checker (.*);

// ===== tb/tb_trimmed_mean_window_filter_unit.sv =====
`timescale 1ns / 100ps

module tb_trimmed_mean_window_filter_unit;

  localparam int WIN_DEPTH       = 8;
  localparam int SAMPLE_BITS     = 16;
  localparam int TRIM_DIVISOR    = WIN_DEPTH - 2;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int SETTLE_CYCLES   = 40;
  localparam int MAX_REPORTS     = 10;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;

  // One row of the directed sequence. Where known_mean is set, the result
  // is obvious from the window contents and is typed in; otherwise the
  // mirror of the filter below works it out.
  typedef struct {
    sample_t sample;
    bit      known_mean;
    sample_t mean;
  } angle_row_t;

  logic    clk_i          = 1'b0;
  logic    rst_ni         = 1'b0;
  logic    in_valid_i     = 1'b0;
  logic    in_stall_o;
  sample_t sample_in_i    = '0;
  logic    out_valid_o;
  logic    out_stall_i    = 1'b0;
  sample_t filtered_out_o;

  // Mirror of the filter state, updated once per accepted sample request.
  sample_t    win_mirror [WIN_DEPTH];
  logic [2:0] mirror_ptr  = '0;
  bit         mirror_full = 1'b0;

  // Filter outputs still owed by the block, oldest first.
  sample_t pending_means_q [$];

  int      mismatch_count = 0;
  bit      hold_off_req   = 1'b0;
  bit      steady_tail    = 1'b0;
  sample_t last_sample    = '0;

  // The first seven rows fill the window and must come straight back. The
  // eighth row is the first real trimmed mean, over a window that holds
  // both extremes. Then the window is flooded with the largest and with the
  // smallest sample, so every entry ties for both maximum and minimum and
  // the mean must equal that sample. The last row puts -1 among smallest
  // samples; the mean is still exactly the smallest sample.
  angle_row_t angle_rows [25] = '{
    '{SAMPLE_MAX,     1'b1, SAMPLE_MAX},
    '{SAMPLE_MIN,     1'b1, SAMPLE_MIN},
    '{16'sh0000,      1'b1, 16'sh0000},
    '{-16'sd1,        1'b1, -16'sd1},
    '{16'sd1,         1'b1, 16'sd1},
    '{16'sh5555,      1'b1, 16'sh5555},
    '{16'shAAAA,      1'b1, 16'shAAAA},
    '{16'sd100,       1'b0, 16'sh0000},
    '{SAMPLE_MAX,     1'b0, 16'sh0000},
    '{SAMPLE_MAX,     1'b0, 16'sh0000},
    '{SAMPLE_MAX,     1'b0, 16'sh0000},
    '{SAMPLE_MAX,     1'b0, 16'sh0000},
    '{SAMPLE_MAX,     1'b0, 16'sh0000},
    '{SAMPLE_MAX,     1'b0, 16'sh0000},
    '{SAMPLE_MAX,     1'b0, 16'sh0000},
    '{SAMPLE_MAX,     1'b1, SAMPLE_MAX},
    '{SAMPLE_MIN,     1'b0, 16'sh0000},
    '{SAMPLE_MIN,     1'b0, 16'sh0000},
    '{SAMPLE_MIN,     1'b0, 16'sh0000},
    '{SAMPLE_MIN,     1'b0, 16'sh0000},
    '{SAMPLE_MIN,     1'b0, 16'sh0000},
    '{SAMPLE_MIN,     1'b0, 16'sh0000},
    '{SAMPLE_MIN,     1'b0, 16'sh0000},
    '{SAMPLE_MIN,     1'b1, SAMPLE_MIN},
    '{-16'sd1,        1'b0, 16'sh0000}
  };

  trimmed_mean_window_filter_unit #(
    .WINDOW_DEPTH(WIN_DEPTH),
    .SAMPLE_WIDTH(SAMPLE_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .sample_in_i   (sample_in_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .filtered_out_o(filtered_out_o)
  );

  always #4 clk_i = ~clk_i;

  // Writes the sample over the oldest window entry and returns what the
  // filter must produce for it: the sample itself while the window is still
  // filling, and afterwards the window sum less one largest and one
  // smallest entry, divided by six with truncation toward zero. The sum is
  // kept in a full integer since eight extreme samples overflow 16 bits.
  function automatic sample_t next_trimmed_mean(input sample_t s);
    int hi;
    int lo;
    int total;
    win_mirror[mirror_ptr] = s;
    if (mirror_ptr == 3'(WIN_DEPTH - 1)) begin
      mirror_full = 1'b1;
    end
    mirror_ptr = mirror_ptr + 3'd1;
    if (!mirror_full) begin
      return s;
    end
    hi    = win_mirror[0];
    lo    = win_mirror[0];
    total = 0;
    for (int k = 0; k < WIN_DEPTH; k++) begin
      if (win_mirror[k] > hi) hi = win_mirror[k];
      if (win_mirror[k] < lo) lo = win_mirror[k];
      total += win_mirror[k];
    end
    return sample_t'((total - hi - lo) / TRIM_DIVISOR);
  endfunction

  // Random angle samples. Plain random words dominate, with extra weight on
  // values near zero (where truncation of negative means matters), on both
  // ends of the range, and on repeats of the previous sample so that ties
  // for the maximum and the minimum show up often.
  function automatic sample_t pick_angle();
    sample_t s;
    case ($urandom_range(0, 7)) inside
      [0:2]:   s = sample_t'($urandom);
      3:       s = sample_t'(int'($urandom_range(0, 32)) - 16);
      4:       s = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
      5:       s = SAMPLE_MAX - sample_t'($urandom_range(0, 15));
      6:       s = SAMPLE_MIN + sample_t'($urandom_range(0, 15));
      default: s = last_sample;
    endcase
    last_sample = s;
    return s;
  endfunction

  // Leaves the input channel idle for the given number of cycles. The data
  // lines carry junk meanwhile, which the block must ignore.
  task automatic idle_sender(input int cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      in_valid_i  <= 1'b0;
      sample_in_i <= sample_t'($urandom);
    end
  endtask

  // Offers one sample request and holds it until the block takes it. The
  // expected output is queued at the edge where the request is accepted.
  // Unless the tail of the run is under way, a random idle burst may come
  // first.
  task automatic send_angle(input sample_t s, input bit known, input sample_t typed_mean);
    sample_t predicted;
    if (!steady_tail && $urandom_range(0, 3) == 0) begin
      idle_sender($urandom_range(1, 16));
    end
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    sample_in_i <= s;
    do @(posedge clk_i); while (in_stall_o);
    predicted = next_trimmed_mean(s);
    pending_means_q.push_back(known ? typed_mean : predicted);
  endtask

  // Lowers the request and waits until every owed result has been taken.
  task automatic drain_results();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_means_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_angles(input int count);
    repeat (count) send_angle(pick_angle(), 1'b0, '0);
  endtask

  // Output side. Stall comes in random bursts, separated by free-flowing
  // stretches of the same kind. On request it stalls for a long, fixed
  // stretch so that the block backs up into its input, and in the tail of
  // the run it does not stall at all.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_off_req) begin
        out_stall_i  <= 1'b1;
        hold_off_req  = 1'b0;
        repeat (HOLD_OFF_CYCLES - 1) @(negedge clk_i);
      end else if (!steady_tail && $urandom_range(0, 2) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end else begin
        out_stall_i <= 1'b0;
        repeat ($urandom_range(0, 15)) @(negedge clk_i);
      end
    end
  end

  // Every result request taken from the block is compared with the oldest
  // owed result. A result with nothing owed is a failure as well.
  always @(posedge clk_i) begin
    sample_t owed;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_means_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("unexpected filter output %0d with no sample pending", filtered_out_o);
        end
      end else begin
        owed = pending_means_q.pop_front();
        if (filtered_out_o !== owed) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("filter output mismatch: expected %0d, got %0d", owed, filtered_out_o);
          end
        end
      end
    end
  end

  // Stimulus. After reset the directed rows run, followed by random samples
  // in several stretches. Midway the output side holds off for a long time
  // while samples keep coming, and afterwards the input side pauses until
  // the block has handed over everything it owes. The last stretch runs
  // with no idling on either side.
  initial begin
    for (int k = 0; k < WIN_DEPTH; k++) begin
      win_mirror[k] = '0;
    end
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (angle_rows[r]) begin
      send_angle(angle_rows[r].sample, angle_rows[r].known_mean, angle_rows[r].mean);
    end

    send_random_angles(700);

    hold_off_req = 1'b1;
    send_random_angles(40);
    drain_results();

    send_random_angles(900);

    steady_tail = 1'b1;
    send_random_angles(285);
    drain_results();

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog. A correct run needs under a fifth of this time even with
  // every idle burst at its longest.
  initial begin
    #4_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
